@@ rtl/core/dss_pkg.sv @@
package dss_pkg;

  // register reset and scan defaults
  localparam logic [15:0] PUSH_LIMIT_RESET   = 16'd5000;
  localparam int          SCAN_SLOTS_DEFAULT = 6;

  // stream widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int LIMIT_W     = 16;
  localparam int TICKS_W     = 17;
  localparam int DIGIT_POS_W = 3;

  // color codes
  localparam logic [1:0] COLOR_WHITE = 2'd1;
  localparam logic [1:0] COLOR_BLACK = 2'd2;

  // display scan slots that drive a digit
  localparam int SLOT_STATE = 0;
  localparam int SLOT_ONES  = 3;
  localparam int SLOT_TENS  = 4;
  localparam int SLOT_HUND  = 5;

  // one input item, last field in the lowest bits
  typedef struct packed {
    logic [7:0] adc_value;
    logic [1:0] disk_color;
    logic       black_exit_seen;
    logic       white_exit_seen;
    logic       abort_released;
    logic       start_stop_released;
  } dss_tick_t;

  // one result item, last field in the lowest bits
  typedef struct packed {
    logic       motor_phase;
    logic [3:0] digit_value;
    logic [2:0] digit_position;
    logic       digit_enable;
    logic [2:0] machine_state;
  } dss_result_t;

  typedef struct packed {
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } dss_bcd_t;

  // byte to three decimal digits: two compares, then a reciprocal multiply by 205/2048
  function automatic dss_bcd_t dss_bcd8(input logic [7:0] a);
    dss_bcd_t    d;
    logic [6:0]  r;
    logic [14:0] prod;
    logic [6:0]  ones_w;
    if (a >= 8'd200) begin
      d.hund = 4'd2;
      r      = 7'(a - 8'd200);
    end else if (a >= 8'd100) begin
      d.hund = 4'd1;
      r      = 7'(a - 8'd100);
    end else begin
      d.hund = 4'd0;
      r      = a[6:0];
    end
    prod   = 15'(r) * 15'd205;
    d.tens = prod[14:11];
    ones_w = r - 7'(d.tens) * 7'd10;
    d.ones = ones_w[3:0];
    return d;
  endfunction

endpackage

@@ rtl/core/dss_seq.sv @@
module dss_seq #(
  parameter int SCAN_SLOTS = dss_pkg::SCAN_SLOTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  dss_pkg::dss_tick_t              tick,
  input  logic [dss_pkg::LIMIT_W-1:0]     push_limit,
  output dss_pkg::dss_result_t            result
);
  import dss_pkg::*;

  localparam int SLOT_W = $clog2(SCAN_SLOTS);

  typedef enum logic [2:0] {
    ST_REST        = 3'd0,
    ST_PUSH        = 3'd1,
    ST_CONV_W      = 3'd2,
    ST_CONV_B      = 3'd3,
    ST_PUSH_STOP   = 3'd4,
    ST_CONV_W_STOP = 3'd5,
    ST_CONV_B_STOP = 3'd6,
    ST_TERM        = 3'd7
  } mode_t;

  mode_t              mode, mode_next;
  logic [TICKS_W-1:0] push_ticks, push_ticks_next;
  logic [TICKS_W-1:0] cnt;
  logic               timeout;
  logic [SLOT_W-1:0]  scan_slot, scan_slot_next;
  logic               phase_flag;
  dss_result_t        result_next;
  dss_bcd_t           bcd;
  logic               ss, ab, wx, bx, is_white, is_black;

  assign ss       = tick.start_stop_released;
  assign ab       = tick.abort_released;
  assign wx       = tick.white_exit_seen;
  assign bx       = tick.black_exit_seen;
  assign is_white = (tick.disk_color == COLOR_WHITE);
  assign is_black = (tick.disk_color == COLOR_BLACK);

  // push timeout count, one bit wider than the limit so it never wraps
  assign cnt     = push_ticks + TICKS_W'(1);
  assign timeout = (cnt > TICKS_W'(push_limit));

  // sequencer transitions
  always_comb begin
    mode_next       = mode;
    push_ticks_next = push_ticks;
    unique case (mode)
      ST_TERM: begin
        if (ss) mode_next = ST_REST;
      end
      ST_REST: begin
        if (ss) mode_next = ST_PUSH;
      end
      ST_PUSH: begin
        push_ticks_next = '0;
        priority if (timeout)         mode_next = ST_REST;
        else if (ss)                  mode_next = ST_PUSH_STOP;
        else if (wx || bx || ab)      mode_next = ST_TERM;
        else if (is_white)            mode_next = ST_CONV_W;
        else if (is_black)            mode_next = ST_CONV_B;
        else begin
          push_ticks_next = cnt;
        end
      end
      ST_CONV_W: begin
        priority if (ss) mode_next = ST_CONV_W_STOP;
        else if (wx)     mode_next = ST_PUSH;
        else if (ab)     mode_next = ST_TERM;
        else             mode_next = ST_CONV_W;
      end
      ST_CONV_B: begin
        priority if (ss) mode_next = ST_CONV_B_STOP;
        else if (bx)     mode_next = ST_PUSH;
        else if (ab)     mode_next = ST_TERM;
        else             mode_next = ST_CONV_B;
      end
      ST_PUSH_STOP: begin
        // count carries over on every exit except the timeout
        push_ticks_next = timeout ? '0 : cnt;
        priority if (timeout)         mode_next = ST_REST;
        else if (wx || bx || ab)      mode_next = ST_TERM;
        else if (is_white)            mode_next = ST_CONV_W_STOP;
        else if (is_black)            mode_next = ST_CONV_B_STOP;
        else                          mode_next = ST_PUSH_STOP;
      end
      ST_CONV_W_STOP: begin
        priority if (wx) mode_next = ST_REST;
        else if (ab)     mode_next = ST_TERM;
        else             mode_next = ST_CONV_W_STOP;
      end
      ST_CONV_B_STOP: begin
        priority if (bx) mode_next = ST_REST;
        else if (ab)     mode_next = ST_TERM;
        else             mode_next = ST_CONV_B_STOP;
      end
      default: mode_next = ST_REST;
    endcase
  end

  // display scan digit
  assign bcd = dss_bcd8(tick.adc_value);

  always_comb begin
    result_next                = '0;
    result_next.machine_state  = mode_next;
    result_next.motor_phase    = phase_flag;
    case (scan_slot)
      SLOT_W'(SLOT_STATE): begin
        result_next.digit_enable = 1'b1;
        result_next.digit_value  = {1'b0, mode_next};
      end
      SLOT_W'(SLOT_ONES): begin
        result_next.digit_enable = 1'b1;
        result_next.digit_value  = bcd.ones;
      end
      SLOT_W'(SLOT_TENS): begin
        result_next.digit_enable = 1'b1;
        result_next.digit_value  = bcd.tens;
      end
      SLOT_W'(SLOT_HUND): begin
        result_next.digit_enable = 1'b1;
        result_next.digit_value  = bcd.hund;
      end
      default: result_next.digit_enable = 1'b0;
    endcase
    if (result_next.digit_enable) begin
      result_next.digit_position = DIGIT_POS_W'(scan_slot) + DIGIT_POS_W'(1);
    end
  end

  // scan slot wrap
  assign scan_slot_next = (scan_slot == SLOT_W'(SCAN_SLOTS - 1)) ? '0
                                                                  : scan_slot + SLOT_W'(1);

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= ST_REST;
      push_ticks <= '0;
      scan_slot  <= '0;
      phase_flag <= 1'b0;
      result     <= '0;
    end else if (adv) begin
      mode       <= mode_next;
      push_ticks <= push_ticks_next;
      scan_slot  <= scan_slot_next;
      phase_flag <= ~phase_flag;
      result     <= result_next;
    end
  end

endmodule

@@ rtl/core/disk_sorter_sequencer.sv @@
// channel   | direction | fields (low bit first)
// ----------+-----------+--------------------------------------------------------------
// s_axis    | in        | start_stop_released, abort_released, white_exit_seen,
//           |           | black_exit_seen, disk_color[1:0], adc_value[7:0]
// m_axis    | out       | machine_state[2:0], digit_enable, digit_position[2:0],
//           |           | digit_value[3:0], motor_phase
// cfg       | in        | push_limit[15:0], written when cfg_we is high
//
// one item per clock unless m_axis stalls; path is input register, then result register
// the sequencer and digit split sit between those two registers in a single pass
// reset clears the state machine, scan, phase flag and both valid flags; limit returns to 5000
// a stalled result holds on m_axis while the input register still takes one more item
module disk_sorter_sequencer #(
  parameter int SCAN_SLOTS = dss_pkg::SCAN_SLOTS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [dss_pkg::LIMIT_W-1:0]        cfg_wdata,      // push_limit
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // start_stop_released, abort_released, white_exit_seen, black_exit_seen,
  // disk_color[1:0], adc_value[7:0], zero pad
  input  logic [dss_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // machine_state[2:0], digit_enable, digit_position[2:0], digit_value[3:0],
  // motor_phase, zero pad
  output logic [dss_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import dss_pkg::*;

  localparam int TICK_W = $bits(dss_tick_t);
  localparam int RES_W  = $bits(dss_result_t);

  logic               in_valid;
  dss_tick_t          in_tick;
  logic               out_valid;
  logic               adv;
  logic [LIMIT_W-1:0] push_limit;
  dss_result_t        result;

  // advance when an input item is held and the result register is free or being drained
  assign adv           = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;

  // control and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      out_valid  <= 1'b0;
      push_limit <= PUSH_LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        push_limit <= cfg_wdata;
      end
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // input item register
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_tick <= dss_tick_t'(s_axis_tdata[TICK_W-1:0]);
    end
  end

  dss_seq #(
    .SCAN_SLOTS (SCAN_SLOTS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .tick       (in_tick),
    .push_limit (push_limit),
    .result     (result)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, result};

endmodule

@@ rtl/core/dss_checker.sv @@
module dss_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [15:0] cfg_wdata,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // an idle scan slot shows no position and no digit
  a_idle_slot: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[3] |-> m_axis_tdata[10:4] == 7'd0)
    else $error("idle slot carries digit data");

  // a driven digit is decimal and sits at a display position
  a_digit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[3] |->
      m_axis_tdata[10:7] <= 4'd9 &&
      (m_axis_tdata[6:4] == 3'd1 || m_axis_tdata[6:4] == 3'd4 ||
       m_axis_tdata[6:4] == 3'd5 || m_axis_tdata[6:4] == 3'd6))
    else $error("bad digit or position");

  // pad bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:12] == 4'd0)
    else $error("result pad bits set");

endmodule

bind disk_sorter_sequencer dss_checker u_dss_checker (.*);
